/* rtl/core/rtsst_pkg.sv */
// Package: constants, request/mode codes and controller/datapath command types.
package rtsst_pkg;
    localparam int SDVL_LIMIT_BITS = 29;
    localparam int TS_W = 32;
    localparam int SN_W = 16;
    localparam int CNT_W = 8;
    localparam int DIV_STEPS = TS_W;
    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_FORCE = 2'd1;
    localparam logic [1:0] REQ_COUNT = 2'd2;

    localparam logic [1:0] MODE_INITIAL = 2'd0;
    localparam logic [1:0] MODE_LEARN = 2'd1;
    localparam logic [1:0] MODE_SCALED = 2'd2;

    typedef struct packed {
        logic load;        // latch input item, compute delta
        logic div_start;   // start divider: a / b
        logic [1:0] div_sel; // 0: delta/stride, 1: ts/stride, 2: (ts-off)/stride
        logic commit_a;    // apply stride decisions; scaled mode uses delta/stride result
        logic commit_off;  // store offset from remainder
        logic commit_b;    // store scaled and final decisions
        logic simple;      // apply non-sample request or short sample path
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic need_div_a;  // scaled mode: delta/stride needed
        logic need_derive; // derive_scaled needed
    } sts_t;

    localparam logic [1:0] DSEL_DELTA = 2'd0;
    localparam logic [1:0] DSEL_TS = 2'd1;
    localparam logic [1:0] DSEL_SC = 2'd2;
endpackage

/* rtl/core/rtp_timestamp_scaling_tracker.sv */
// Top level: scaled RTP timestamp tracker.
// Usage:
//   Input channel in_valid/in_ready carries one request transaction:
//   req_type, timestamp, seq_num, target_mode. Output channel
//   out_valid/out_ready carries one result transaction per request:
//   mode_now, stride_out, scaled_out, offset_out, deducible, learn_count_out.
// Short paths: force, count and short sample requests skip the divider.
//   A sample in learning mode runs two 32-step divisions on the shared
//   radix-2 divider; in scaled mode with a stride change a third
//   division is added. The divider sets the rate.
// Throughput: one request at a time; the next is taken in the same cycle
//   the result transaction completes.
// Reset: rst_n clears mode, stride, scaled, offset, flags and counters to 0.
// Stall: while a result is offered and out_ready is low, it is held and no request is taken.
module rtp_timestamp_scaling_tracker (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [1:0] req_type,
    input  logic [rtsst_pkg::TS_W-1:0] timestamp,
    input  logic [rtsst_pkg::SN_W-1:0] seq_num,
    input  logic [1:0] target_mode,
    output logic out_valid,
    input  logic out_ready,
    output logic [1:0] mode_now,
    output logic [rtsst_pkg::TS_W-1:0] stride_out,
    output logic [rtsst_pkg::TS_W-1:0] scaled_out,
    output logic [rtsst_pkg::TS_W-1:0] offset_out,
    output logic deducible,
    output logic [rtsst_pkg::CNT_W-1:0] learn_count_out
);
    import rtsst_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rtsst_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
    );

    rtsst_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .req_type(req_type), .timestamp(timestamp), .seq_num(seq_num),
        .target_mode(target_mode), .mode_now(mode_now), .stride_out(stride_out),
        .scaled_out(scaled_out), .offset_out(offset_out), .deducible(deducible),
        .learn_count_out(learn_count_out)
    );

    a_no_accept_while_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("request taken while result stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(stride_out)
            && $stable(mode_now) && $stable(learn_count_out)))
        else $error("result changed while stalled");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mode_now != 2'd3))
        else $error("mode out of range");
endmodule

/* rtl/core/rtsst_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module rtsst_div (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [rtsst_pkg::TS_W-1:0] dividend,
    input  logic [rtsst_pkg::TS_W-1:0] divisor,
    output logic done,
    output logic [rtsst_pkg::TS_W-1:0] quot,
    output logic [rtsst_pkg::TS_W-1:0] rem
);
    import rtsst_pkg::*;

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [TS_W-1:0] q_reg, q_next, d_reg, d_next;
    logic [TS_W:0] r_reg, r_next;
    logic [TS_W:0] trial;

    always_comb
    begin
        trial = {r_reg[TS_W-1:0], q_reg[TS_W-1]} - {1'b0, d_reg};
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        if (start)
        begin
            q_next = dividend;
            d_next = divisor;
            r_next = '0;
            cnt_next = STEP_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[TS_W])
            begin
                r_next = trial;
                q_next = {q_reg[TS_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[TS_W-1:0], q_reg[TS_W-1]};
                q_next = {q_reg[TS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem = r_reg[TS_W-1:0];
endmodule

/* rtl/core/rtsst_dp.sv */
// Datapath: tracker state, delta, divider and update decisions.
module rtsst_dp (
    input  logic clk,
    input  logic rst_n,
    input  rtsst_pkg::cmd_t cmd,
    output rtsst_pkg::sts_t sts,
    input  logic [1:0] req_type,
    input  logic [rtsst_pkg::TS_W-1:0] timestamp,
    input  logic [rtsst_pkg::SN_W-1:0] seq_num,
    input  logic [1:0] target_mode,
    output logic [1:0] mode_now,
    output logic [rtsst_pkg::TS_W-1:0] stride_out,
    output logic [rtsst_pkg::TS_W-1:0] scaled_out,
    output logic [rtsst_pkg::TS_W-1:0] offset_out,
    output logic deducible,
    output logic [rtsst_pkg::CNT_W-1:0] learn_count_out
);
    import rtsst_pkg::*;

    logic [1:0] mode_reg, req_reg, tgt_reg;
    logic [TS_W-1:0] last_ts_reg, stride_reg, scaled_reg, offset_reg;
    logic [SN_W-1:0] last_sn_reg;
    logic ded_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [TS_W-1:0] ts_reg, prev_ts_reg, delta_reg, sndiff_reg, old_sc_reg, old_off_reg;
    logic [TS_W-1:0] div_a, div_b, quot, rem;
    logic div_done;
    logic fits;
    logic [TS_W-1:0] delta_c;
    logic [TS_W-1:0] sn_d;
    logic old_mode_scaled;
    logic old_mode_next;

    assign delta_c = (timestamp >= last_ts_reg) ? timestamp - last_ts_reg
                                                 : last_ts_reg - timestamp;
    assign sn_d = {{(TS_W-SN_W){1'b0}}, seq_num} - {{(TS_W-SN_W){1'b0}}, last_sn_reg};
    assign fits = (SDVL_LIMIT_BITS >= TS_W) ? 1'b1
                : ((delta_reg >> SDVL_LIMIT_BITS) == '0);

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_DELTA: div_a = delta_reg;
            DSEL_TS: div_a = ts_reg;
            default: div_a = ts_reg - offset_reg;
        endcase
        div_b = stride_reg;
    end

    rtsst_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(div_a), .divisor(div_b),
        .done(div_done), .quot(quot), .rem(rem)
    );

    assign sts.div_done = div_done;
    assign sts.need_div_a = (req_reg == REQ_SAMPLE) && (mode_reg == MODE_SCALED)
        && (delta_reg != '0) && fits && (delta_reg != stride_reg)
        && (stride_reg != '0);
    assign sts.need_derive = (req_reg == REQ_SAMPLE) && (delta_reg != '0) && fits
        && ((mode_reg == MODE_LEARN) || (mode_reg == MODE_SCALED));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_INITIAL;
            last_ts_reg <= '0;
            last_sn_reg <= '0;
            stride_reg <= '0;
            scaled_reg <= '0;
            offset_reg <= '0;
            ded_reg <= 1'b0;
            cnt_reg <= '0;
            req_reg <= REQ_COUNT;
            tgt_reg <= MODE_INITIAL;
        end
        else
        begin
            if (cmd.load)
            begin
                req_reg <= req_type;
                tgt_reg <= target_mode;
                if (req_type == REQ_SAMPLE)
                begin
                    last_ts_reg <= timestamp;
                    last_sn_reg <= seq_num;
                end
            end
            if (cmd.simple)
            begin
                case (req_reg)
                    REQ_SAMPLE:
                    begin
                        if (mode_reg == MODE_LEARN)
                        begin
                            if (!fits)
                                mode_reg <= MODE_INITIAL;
                            else if (delta_reg == '0)
                                cnt_reg <= '0;
                        end
                        else if (mode_reg == MODE_SCALED)
                        begin
                            if (delta_reg == '0)
                            begin
                                mode_reg <= MODE_LEARN;
                                cnt_reg <= '0;
                            end
                            else if (!fits)
                                mode_reg <= MODE_INITIAL;
                        end
                    end
                    REQ_FORCE:
                        if (tgt_reg != 2'd3)
                            mode_reg <= tgt_reg;
                    REQ_COUNT:
                        if (cnt_reg != '1)
                            cnt_reg <= cnt_reg + 1'b1;
                    default: ;
                endcase
            end
            if (cmd.commit_a)
            begin
                if (mode_reg == MODE_LEARN)
                begin
                    if (delta_reg != stride_reg)
                        cnt_reg <= '0;
                    stride_reg <= delta_reg;
                end
                else if (delta_reg != stride_reg)
                begin
                    if (stride_reg == '0 || rem != '0)
                    begin
                        mode_reg <= MODE_LEARN;
                        cnt_reg <= '0;
                        stride_reg <= delta_reg;
                    end
                    else if (quot != sndiff_reg)
                    begin
                        mode_reg <= MODE_LEARN;
                        cnt_reg <= '0;
                    end
                end
            end
            if (cmd.commit_off)
                offset_reg <= rem;
            if (cmd.commit_b)
            begin
                scaled_reg <= quot;
                if (mode_reg == MODE_SCALED)
                begin
                    ded_reg <= (quot - old_sc_reg) == sndiff_reg;
                    if (ts_reg < prev_ts_reg && old_off_reg != offset_reg)
                    begin
                        mode_reg <= MODE_LEARN;
                        cnt_reg <= '0;
                    end
                end
                else if (old_mode_scaled)
                    ded_reg <= 1'b0;
            end
        end
    end

    assign old_mode_next = (mode_reg == MODE_SCALED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            old_mode_scaled <= 1'b0;
        else if (cmd.load)
            old_mode_scaled <= old_mode_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ts_reg <= timestamp;
            prev_ts_reg <= last_ts_reg;
            delta_reg <= delta_c;
            sndiff_reg <= sn_d;
            old_sc_reg <= scaled_reg;
            old_off_reg <= offset_reg;
        end
    end

    assign mode_now = mode_reg;
    assign stride_out = stride_reg;
    assign scaled_out = scaled_reg;
    assign offset_out = offset_reg;
    assign deducible = ded_reg;
    assign learn_count_out = cnt_reg;
endmodule

/* rtl/core/rtsst_ctrl.sv */
// Controller: sequences load, divisions, commits and the output handshake.
module rtsst_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  rtsst_pkg::sts_t sts,
    output rtsst_pkg::cmd_t cmd
);
    import rtsst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC = 3'd1;
    localparam logic [2:0] S_DIVA = 3'd2;
    localparam logic [2:0] S_DIVT = 3'd3;
    localparam logic [2:0] S_DIVS = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic started_reg, started_next;

    always_comb
    begin
        state_next = state_reg;
        started_next = started_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                started_next = 1'b0;
                if (sts.need_div_a)
                    state_next = S_DIVA;
                else if (sts.need_derive)
                begin
                    cmd.commit_a = 1'b1;
                    state_next = S_DIVT;
                end
                else
                begin
                    cmd.simple = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_DIVA:
            begin
                cmd.div_sel = DSEL_DELTA;
                cmd.div_start = !started_reg;
                started_next = 1'b1;
                if (sts.div_done)
                begin
                    cmd.commit_a = 1'b1;
                    started_next = 1'b0;
                    state_next = S_DIVT;
                end
            end
            S_DIVT:
            begin
                cmd.div_sel = DSEL_TS;
                cmd.div_start = !started_reg;
                started_next = 1'b1;
                if (sts.div_done)
                begin
                    cmd.commit_off = 1'b1;
                    started_next = 1'b0;
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                cmd.div_sel = DSEL_SC;
                cmd.div_start = !started_reg;
                started_next = 1'b1;
                if (sts.div_done)
                begin
                    cmd.commit_b = 1'b1;
                    started_next = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                in_ready = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load = 1'b1;
                        state_next = S_DEC;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            started_reg <= started_next;
        end
    end
endmodule

/* tb/tb_rtsst_checker.sv */
// Checker for the timestamp scaling tracker: predicts each result and compares it.
`timescale 1ns / 100ps
module tb_rtsst_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  logic [1:0] req_type,
    input  logic [rtsst_pkg::TS_W-1:0] timestamp,
    input  logic [rtsst_pkg::SN_W-1:0] seq_num,
    input  logic [1:0] target_mode,
    input  logic out_valid,
    input  logic out_ready,
    input  logic [1:0] mode_now,
    input  logic [rtsst_pkg::TS_W-1:0] stride_out,
    input  logic [rtsst_pkg::TS_W-1:0] scaled_out,
    input  logic [rtsst_pkg::TS_W-1:0] offset_out,
    input  logic deducible,
    input  logic [rtsst_pkg::CNT_W-1:0] learn_count_out,
    output int errors,
    output int pending,
    output int results_seen
);
    import rtsst_pkg::*;

    typedef struct packed {
        logic [1:0] mode;
        logic [31:0] stride;
        logic [31:0] scaled;
        logic [31:0] offset;
        logic ded;
        logic [7:0] cnt;
    } track_t;

    track_t cur;
    logic [31:0] prev_ts;
    logic [15:0] prev_sn;
    track_t expected_q[$];

    function automatic logic fits_limit(logic [31:0] v);
        return (v >> SDVL_LIMIT_BITS) == 0;
    endfunction

    task automatic apply_sample(logic [31:0] ts, logic [15:0] sn);
        logic [31:0] delta;
        logic [31:0] sn_diff;
        logic [31:0] prior_scaled;
        logic [31:0] old_off;
        logic [31:0] pts;
        pts = prev_ts;
        delta = (ts >= pts) ? ts - pts : pts - ts;
        sn_diff = {16'd0, sn} - {16'd0, prev_sn};
        prior_scaled = cur.scaled;
        old_off = cur.offset;
        prev_ts = ts;
        prev_sn = sn;
        if (cur.mode == MODE_LEARN)
        begin
            if (!fits_limit(delta))
                cur.mode = MODE_INITIAL;
            else if (delta == 0)
                cur.cnt = 0;
            else
            begin
                if (delta != cur.stride)
                    cur.cnt = 0;
                cur.stride = delta;
                cur.offset = ts % cur.stride;
                cur.scaled = (ts - cur.offset) / cur.stride;
            end
        end
        else if (cur.mode == MODE_SCALED)
        begin
            if (delta == 0)
            begin
                cur.mode = MODE_LEARN;
                cur.cnt = 0;
                return;
            end
            if (!fits_limit(delta))
            begin
                cur.mode = MODE_INITIAL;
                return;
            end
            if (delta != cur.stride)
            begin
                if (cur.stride == 0 || (delta % cur.stride) != 0)
                begin
                    cur.mode = MODE_LEARN;
                    cur.cnt = 0;
                    cur.stride = delta;
                end
                else if ((delta / cur.stride) != sn_diff)
                begin
                    cur.mode = MODE_LEARN;
                    cur.cnt = 0;
                end
            end
            cur.offset = ts % cur.stride;
            cur.scaled = (ts - cur.offset) / cur.stride;
            cur.ded = (cur.mode == MODE_SCALED) && ((cur.scaled - prior_scaled) == sn_diff);
            if (ts < pts && old_off != cur.offset)
            begin
                cur.mode = MODE_LEARN;
                cur.cnt = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        track_t got;
        track_t exp_r;
        if (!rst_n)
        begin
            cur = '0;
            prev_ts = 0;
            prev_sn = 0;
            expected_q.delete();
            errors = 0;
            results_seen = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{mode_now, stride_out, scaled_out, offset_out, deducible,
                        learn_count_out};
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction %h", $time, got);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got.mode != exp_r.mode)
                    begin
                        errors++;
                        $display("%0t: mode_now exp %0d got %0d", $time, exp_r.mode, got.mode);
                    end
                    if (got.stride != exp_r.stride)
                    begin
                        errors++;
                        $display("%0t: stride_out exp %h got %h", $time, exp_r.stride,
                                 got.stride);
                    end
                    if (got.scaled != exp_r.scaled)
                    begin
                        errors++;
                        $display("%0t: scaled_out exp %h got %h", $time, exp_r.scaled,
                                 got.scaled);
                    end
                    if (got.offset != exp_r.offset)
                    begin
                        errors++;
                        $display("%0t: offset_out exp %h got %h", $time, exp_r.offset,
                                 got.offset);
                    end
                    if (got.ded != exp_r.ded)
                    begin
                        errors++;
                        $display("%0t: deducible exp %0d got %0d", $time, exp_r.ded, got.ded);
                    end
                    if (got.cnt != exp_r.cnt)
                    begin
                        errors++;
                        $display("%0t: learn_count_out exp %0d got %0d", $time, exp_r.cnt,
                                 got.cnt);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (req_type == REQ_SAMPLE)
                    apply_sample(timestamp, seq_num);
                else if (req_type == REQ_FORCE)
                begin
                    if (target_mode <= MODE_SCALED)
                        cur.mode = target_mode;
                end
                else if (req_type == REQ_COUNT)
                begin
                    if (cur.cnt != 8'hff)
                        cur.cnt++;
                end
                expected_q.push_back(cur);
            end
            pending = expected_q.size();
        end
    end
endmodule

/* tb/tb_rtp_timestamp_scaling_tracker.sv */
// Testbench top for the timestamp scaling tracker: stimulus, clock and verdict.
`timescale 1ns / 100ps
module tb_rtp_timestamp_scaling_tracker;
    import rtsst_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] req_type;
    logic [TS_W-1:0] timestamp;
    logic [SN_W-1:0] seq_num;
    logic [1:0] target_mode;
    logic out_valid;
    logic out_ready;
    logic [1:0] mode_now;
    logic [TS_W-1:0] stride_out;
    logic [TS_W-1:0] scaled_out;
    logic [TS_W-1:0] offset_out;
    logic deducible;
    logic [CNT_W-1:0] learn_count_out;
    int errors;
    int pending;
    int results_seen;
    int cycles;
    int hold_off;
    logic [31:0] ts_run;
    logic [15:0] sn_run;
    logic [31:0] step;

    rtp_timestamp_scaling_tracker dut (.*);

    tb_rtsst_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    task automatic send(logic [1:0] rt, logic [31:0] ts, logic [15:0] sn, logic [1:0] tm);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        timestamp <= ts;
        seq_num <= sn;
        target_mode <= tm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic sample(logic [31:0] ts, logic [15:0] sn);
        send(REQ_SAMPLE, ts, sn, 2'($urandom));
    endtask

    task automatic force_mode(logic [1:0] m);
        send(REQ_FORCE, $urandom, 16'($urandom), m);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycles <= 0;
        else
        begin
            cycles <= cycles + 1;
            if (cycles > 3000000)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        int g;
        if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
        begin
            g = $urandom_range(0, 99);
            out_ready <= (g >= 30) || (cycles % 400 < 100);
            if (g < 2)
                hold_off <= $urandom_range(20, 150);
        end
    end

    initial
    begin
        int kind;
        in_valid = 1'b0;
        req_type = '0;
        timestamp = '0;
        seq_num = '0;
        target_mode = '0;
        out_ready = 1'b0;
        hold_off = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sample(32'h0000_1000, 16'd1);
        force_mode(MODE_SCALED);
        sample(32'h0000_2000, 16'd2);
        force_mode(MODE_LEARN);
        sample(32'h0000_3000, 16'd3);
        sample(32'h0000_4000, 16'd4);
        sample(32'h0000_4000, 16'd5);
        sample(32'h0000_5000, 16'd6);
        repeat (3) send(REQ_COUNT, '0, '0, '0);
        force_mode(MODE_SCALED);
        sample(32'h0000_6000, 16'd7);
        sample(32'h0000_8000, 16'd9);
        sample(32'h0000_a000, 16'd10);
        sample(32'h0000_a800, 16'd11);
        force_mode(MODE_SCALED);
        sample(32'h0000_a800, 16'd12);
        force_mode(MODE_SCALED);
        sample(32'hffff_ffff, 16'hffff);
        force_mode(2'd3);
        send(2'd3, 32'hffff_ffff, 16'hffff, 2'd3);
        force_mode(MODE_LEARN);
        sample(32'h0000_0003, 16'h0000);
        force_mode(MODE_SCALED);
        sample(32'hffff_fffe, 16'hffff);
        force_mode(MODE_INITIAL);
        drain();

        // long receiver hold-off while the sender keeps offering
        @(posedge clk);
        hold_off = 400;
        @(negedge clk);
        repeat (6) send(REQ_COUNT, '0, '0, '0);
        drain();

        for (int i = 0; i < 300; i++)
            send(REQ_COUNT, '0, '0, '0);

        ts_run = $urandom;
        sn_run = 16'($urandom);
        for (int n = 0; n < 650;)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                step = $urandom_range(1, 4000);
                if (kind == 0)
                    step = $urandom_range(0, 1) ? 32'd1 << $urandom_range(0, 31) : $urandom;
                force_mode(MODE_LEARN);
                n++;
                for (int k = 0; k < $urandom_range(2, 6); k++)
                begin
                    sn_run = sn_run + 16'd1;
                    ts_run = ts_run + step;
                    sample(ts_run, sn_run);
                    n++;
                end
                if ($urandom_range(0, 1))
                begin
                    force_mode(MODE_SCALED);
                    n++;
                end
                for (int k = 0; k < $urandom_range(2, 8); k++)
                begin
                    kind = $urandom_range(0, 9);
                    sn_run = 16'(sn_run + ((kind == 0) ? $urandom_range(2, 4) : 1));
                    ts_run = ts_run + step * ((kind == 0) ? $urandom_range(2, 4) : 1);
                    if (kind == 1)
                        ts_run = ts_run + $urandom_range(1, 50);
                    if (kind == 2)
                        ts_run = ts_run - step * 3;
                    sample(ts_run, sn_run);
                    n++;
                end
            end
            else if (kind == 7)
            begin
                send(2'($urandom), $urandom, 16'($urandom), 2'($urandom));
                n++;
            end
            else
            begin
                sample($urandom, 16'($urandom));
                n++;
            end
        end
        drain();

        $display("Covered directed mode edges, saturating count, wrap and loss cases,");
        $display("and %0d results from random stride sequences.", results_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* rtp_timestamp_scaling_tracker.f */
rtl/core/rtsst_pkg.sv
rtl/core/rtsst_div.sv
rtl/core/rtsst_dp.sv
rtl/core/rtsst_ctrl.sv
rtl/core/rtp_timestamp_scaling_tracker.sv
tb/tb_rtsst_checker.sv
tb/tb_rtp_timestamp_scaling_tracker.sv
